// ===== src/tpeu_pkg.sv =====
// ----------------------------------------------------------------------------
// tpeu_pkg: shared types and constants for the three-phase encoder reporter
// Phase step decode, serial frame counts and configuration register indexes.
// ----------------------------------------------------------------------------
package tpeu_pkg;

  typedef logic [2:0] phase_t;
  typedef logic [3:0] bit_cnt_t;
  typedef logic [7:0] char_t;
  typedef logic [1:0] cfg_idx_t;
  typedef logic [1:0] step_dir_t;

  // Step direction codes
  localparam step_dir_t DIR_NONE = 2'd0;
  localparam step_dir_t DIR_FWD  = 2'd1;
  localparam step_dir_t DIR_REV  = 2'd2;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Configuration register indexes
  localparam cfg_idx_t REG_UP_CHAR        = 2'd0;
  localparam cfg_idx_t REG_DOWN_CHAR      = 2'd1;
  localparam cfg_idx_t REG_DRIVER_PRESENT = 2'd2;

  localparam char_t UP_CHAR_RST   = 8'd60;  // '<'
  localparam char_t DOWN_CHAR_RST = 8'd66;  // 'B'

  // Frame counts: start bit at 10, data at 9..2, stop at 1
  localparam bit_cnt_t CNT_IDLE      = 4'd0;
  localparam bit_cnt_t CNT_STOP      = 4'd1;
  localparam bit_cnt_t CNT_START     = 4'd10;
  localparam bit_cnt_t CNT_PULSE_SET = 4'd6;
  localparam bit_cnt_t CNT_PULSE_CLR = 4'd4;

  // Key is {new, old}; forward and reverse follow the six-state phase cycle
  function automatic step_dir_t classify_step(input phase_t new_ph, input phase_t old_ph);
    logic [5:0] key;
    step_dir_t  dir;
    key = {new_ph, old_ph};
    case (key)
      6'o64, 6'o26, 6'o32, 6'o13, 6'o51, 6'o45: dir = DIR_FWD;
      6'o46, 6'o54, 6'o15, 6'o31, 6'o23, 6'o62: dir = DIR_REV;
      default:                                  dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

// ===== src/three_phase_encoder_uart_reporter.sv =====
// ----------------------------------------------------------------------------
// three_phase_encoder_uart_reporter: encoder step decoder with 8N1 reporter
// An accepted request's result is loaded into the output reg in the next cycle.
// Throughput: one request per cycle; in_stall only while a held result waits.
// Reset: synchronous active-low rst_n; line at mark, counters idle, config at
// its defaults ('<', 'B', pin inverted).
// ----------------------------------------------------------------------------
module three_phase_encoder_uart_reporter
  import tpeu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // request channel
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_kind,
  input  logic [2:0] in_phase_bits,
  // result channel
  output logic     out_valid,
  input  logic     out_stall,
  output logic     out_tx_pin,
  output logic     out_pulse_pin,
  output logic     out_step_up,
  output logic     out_step_down,
  output logic     out_sample_ignored,
  output logic     out_tx_busy,
  // configuration write channel
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration
  char_t    up_char_r, down_char_r;
  logic     driver_present_r;

  // encoder and transmitter state
  phase_t   old_phases_r, old_phases_nxt;
  bit_cnt_t bit_count_r, bit_count_nxt;
  char_t    shift_byte_r, shift_byte_nxt;
  logic     line_mark_r, line_mark_nxt;
  logic     pulse_level_r, pulse_level_nxt;
  logic     pending_valid_r, pending_valid_nxt;
  char_t    pending_char_r, pending_char_nxt;

  // result register
  logic     out_valid_r;
  logic     tx_pin_r, pulse_pin_r, step_up_r, step_down_r, ignored_r, busy_r;
  logic     step_up_nxt, step_down_nxt, ignored_nxt;

  logic      in_accept;
  step_dir_t dir;
  bit_cnt_t  cnt_dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign dir     = classify_step(in_phase_bits, old_phases_r);
  assign cnt_dec = bit_count_r - 4'd1;

  always_comb begin
    old_phases_nxt    = old_phases_r;
    bit_count_nxt     = bit_count_r;
    shift_byte_nxt    = shift_byte_r;
    line_mark_nxt     = line_mark_r;
    pulse_level_nxt   = pulse_level_r;
    pending_valid_nxt = pending_valid_r;
    pending_char_nxt  = pending_char_r;
    step_up_nxt       = 1'b0;
    step_down_nxt     = 1'b0;
    ignored_nxt       = 1'b0;

    if (in_kind == KIND_TICK) begin
      if (bit_count_r == CNT_IDLE || bit_count_r == CNT_STOP) begin
        line_mark_nxt = 1'b1;
      end else if (bit_count_r == CNT_START) begin
        line_mark_nxt = 1'b0;
      end else begin
        // data bit, LSB first
        line_mark_nxt  = shift_byte_r[0];
        shift_byte_nxt = {1'b0, shift_byte_r[7:1]};
        if (bit_count_r == CNT_PULSE_SET) begin
          pulse_level_nxt = 1'b1;
        end else if (bit_count_r == CNT_PULSE_CLR) begin
          pulse_level_nxt = 1'b0;
        end
      end
      if (bit_count_r != CNT_IDLE) begin
        bit_count_nxt = cnt_dec;
        // frame done: start the waiting character
        if (cnt_dec == CNT_IDLE && pending_valid_r) begin
          shift_byte_nxt    = pending_char_r;
          bit_count_nxt     = CNT_START;
          pending_valid_nxt = 1'b0;
        end
      end
    end else if (pending_valid_r) begin
      // drop the sample, keep old phases
      ignored_nxt = 1'b1;
    end else begin
      old_phases_nxt = in_phase_bits;
      if (dir != DIR_NONE) begin
        step_up_nxt   = (dir == DIR_FWD);
        step_down_nxt = (dir == DIR_REV);
        if (bit_count_r == CNT_IDLE) begin
          shift_byte_nxt = (dir == DIR_FWD) ? up_char_r : down_char_r;
          bit_count_nxt  = CNT_START;
        end else begin
          pending_char_nxt  = (dir == DIR_FWD) ? up_char_r : down_char_r;
          pending_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_char_r        <= UP_CHAR_RST;
      down_char_r      <= DOWN_CHAR_RST;
      driver_present_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UP_CHAR:        up_char_r        <= cfg_data;
        REG_DOWN_CHAR:      down_char_r      <= cfg_data;
        REG_DRIVER_PRESENT: driver_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_phases_r    <= '0;
      bit_count_r     <= CNT_IDLE;
      shift_byte_r    <= '0;
      line_mark_r     <= 1'b1;
      pulse_level_r   <= 1'b0;
      pending_valid_r <= 1'b0;
      pending_char_r  <= '0;
    end else if (in_accept) begin
      old_phases_r    <= old_phases_nxt;
      bit_count_r     <= bit_count_nxt;
      shift_byte_r    <= shift_byte_nxt;
      line_mark_r     <= line_mark_nxt;
      pulse_level_r   <= pulse_level_nxt;
      pending_valid_r <= pending_valid_nxt;
      pending_char_r  <= pending_char_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded only when a request is taken
  always_ff @(posedge clk) begin
    if (in_accept) begin
      tx_pin_r    <= driver_present_r ? line_mark_nxt : ~line_mark_nxt;
      pulse_pin_r <= pulse_level_nxt;
      step_up_r   <= step_up_nxt;
      step_down_r <= step_down_nxt;
      ignored_r   <= ignored_nxt;
      busy_r      <= (bit_count_nxt != CNT_IDLE);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_pin         = tx_pin_r;
  assign out_pulse_pin      = pulse_pin_r;
  assign out_step_up        = step_up_r;
  assign out_step_down      = step_down_r;
  assign out_sample_ignored = ignored_r;
  assign out_tx_busy        = busy_r;

endmodule

// ===== dv/encoder_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_report_checker: result predictor and comparator for the reporter
// Watches the request, result and register write channels, predicts one
// report per accepted request and compares it with the oldest one waiting.
// ----------------------------------------------------------------------------
module encoder_report_checker
  import tpeu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  logic     in_kind,
  input  phase_t   in_phase_bits,
  input  logic     out_valid,
  input  logic     out_stall,
  input  logic     out_tx_pin,
  input  logic     out_pulse_pin,
  input  logic     out_step_up,
  input  logic     out_step_down,
  input  logic     out_sample_ignored,
  input  logic     out_tx_busy,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  char_t    cfg_data,
  output int       fail_count,
  output int       outstanding
);

  typedef struct packed {
    logic tx_pin;
    logic pulse_pin;
    logic step_up;
    logic step_down;
    logic sample_ignored;
    logic tx_busy;
  } encoder_report_t;

  encoder_report_t expected_reports[$];
  int              mismatches = 0;

  // predicted block state
  char_t    fwd_char;
  char_t    rev_char;
  logic     pin_direct;
  phase_t   prev_phase;
  bit_cnt_t frame_cnt;
  char_t    tx_shift;
  logic     line_level;
  logic     pulse_level;
  logic     slot_full;
  char_t    slot_char;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // position on the six-state cycle, -1 for the two illegal codes
  function automatic int cycle_pos(input phase_t p);
    case (p)
      3'd4:    return 0;
      3'd6:    return 1;
      3'd2:    return 2;
      3'd3:    return 3;
      3'd1:    return 4;
      3'd5:    return 5;
      default: return -1;
    endcase
  endfunction

  function automatic step_dir_t step_between(input phase_t from_ph, input phase_t to_ph);
    int pf;
    int pt;
    pf = cycle_pos(from_ph);
    pt = cycle_pos(to_ph);
    if (pf < 0 || pt < 0) return DIR_NONE;
    if (pt == (pf + 1) % 6) return DIR_FWD;
    if (pf == (pt + 1) % 6) return DIR_REV;
    return DIR_NONE;
  endfunction

  task automatic restore_reset();
    fwd_char    = UP_CHAR_RST;
    rev_char    = DOWN_CHAR_RST;
    pin_direct  = 1'b0;
    prev_phase  = '0;
    frame_cnt   = CNT_IDLE;
    tx_shift    = '0;
    line_level  = 1'b1;
    pulse_level = 1'b0;
    slot_full   = 1'b0;
    slot_char   = '0;
  endtask

  function automatic encoder_report_t predict_report(input logic kind, input phase_t ph);
    encoder_report_t r;
    step_dir_t       dir;
    char_t           ch;
    r = '0;
    if (kind == KIND_TICK) begin
      if (frame_cnt == CNT_IDLE || frame_cnt == CNT_STOP) begin
        line_level = 1'b1;
      end else if (frame_cnt == CNT_START) begin
        line_level = 1'b0;
      end else begin
        line_level = tx_shift[0];
        tx_shift   = tx_shift >> 1;
        if (frame_cnt == CNT_PULSE_SET) begin
          pulse_level = 1'b1;
        end else if (frame_cnt == CNT_PULSE_CLR) begin
          pulse_level = 1'b0;
        end
      end
      if (frame_cnt != CNT_IDLE) begin
        frame_cnt = frame_cnt - 4'd1;
        // frame done: start the waiting character right away
        if (frame_cnt == CNT_IDLE && slot_full) begin
          tx_shift  = slot_char;
          frame_cnt = CNT_START;
          slot_full = 1'b0;
        end
      end
    end else if (slot_full) begin
      r.sample_ignored = 1'b1;
    end else begin
      dir = step_between(prev_phase, ph);
      if (dir != DIR_NONE) begin
        ch          = (dir == DIR_FWD) ? fwd_char : rev_char;
        r.step_up   = (dir == DIR_FWD);
        r.step_down = (dir == DIR_REV);
        if (frame_cnt == CNT_IDLE) begin
          tx_shift  = ch;
          frame_cnt = CNT_START;
        end else begin
          slot_char = ch;
          slot_full = 1'b1;
        end
      end
      prev_phase = ph;
    end
    r.tx_pin    = pin_direct ? line_level : ~line_level;
    r.pulse_pin = pulse_level;
    r.tx_busy   = (frame_cnt != CNT_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    encoder_report_t seen;
    encoder_report_t want;
    if (!rst_n) begin
      restore_reset();
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UP_CHAR:        fwd_char   = cfg_data;
          REG_DOWN_CHAR:      rev_char   = cfg_data;
          REG_DRIVER_PRESENT: pin_direct = cfg_data[0];
          default: ;
        endcase
      end
      // retire before predicting: a result never belongs to the same-edge request
      if (out_valid && !out_stall) begin
        seen = '{out_tx_pin, out_pulse_pin, out_step_up, out_step_down,
                 out_sample_ignored, out_tx_busy};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected report tx=%0b pulse=%0b up=%0b dn=%0b ign=%0b busy=%0b",
                     $time, seen.tx_pin, seen.pulse_pin, seen.step_up, seen.step_down,
                     seen.sample_ignored, seen.tx_busy);
        end else begin
          want = expected_reports.pop_front();
          if (seen.tx_pin != want.tx_pin || seen.pulse_pin != want.pulse_pin ||
              seen.step_up != want.step_up || seen.step_down != want.step_down ||
              seen.sample_ignored != want.sample_ignored || seen.tx_busy != want.tx_busy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] report differs exp tx=%0b pulse=%0b up=%0b dn=%0b ign=%0b busy=%0b %s",
                       $time, want.tx_pin, want.pulse_pin, want.step_up, want.step_down,
                       want.sample_ignored, want.tx_busy,
                       $sformatf("act tx=%0b pulse=%0b up=%0b dn=%0b ign=%0b busy=%0b",
                                 seen.tx_pin, seen.pulse_pin, seen.step_up, seen.step_down,
                                 seen.sample_ignored, seen.tx_busy));
          end
        end
      end
      if (in_valid && !in_stall)
        expected_reports.push_back(predict_report(in_kind, in_phase_bits));
    end
    fail_count  <= mismatches;
    outstanding <= expected_reports.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the encoder step reporter
// Drives phase samples and baud ticks under varying sender gaps and result
// stalls, rewrites the registers between runs and relies on the checker.
// ----------------------------------------------------------------------------
module testbench
  import tpeu_pkg::*;
();

  localparam int QUIET_LIMIT = 2000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     in_kind = KIND_SAMPLE;
  phase_t   in_phase_bits = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  logic     out_tx_pin;
  logic     out_pulse_pin;
  logic     out_step_up;
  logic     out_step_down;
  logic     out_sample_ignored;
  logic     out_tx_busy;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = REG_UP_CHAR;
  char_t    cfg_data = '0;

  int fail_count;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int walk_pos       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_phase_encoder_uart_reporter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_phase_bits      (in_phase_bits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tx_pin         (out_tx_pin),
    .out_pulse_pin      (out_pulse_pin),
    .out_step_up        (out_step_up),
    .out_step_down      (out_step_down),
    .out_sample_ignored (out_sample_ignored),
    .out_tx_busy        (out_tx_busy),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  encoder_report_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_phase_bits      (in_phase_bits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tx_pin         (out_tx_pin),
    .out_pulse_pin      (out_pulse_pin),
    .out_step_up        (out_step_up),
    .out_step_down      (out_step_down),
    .out_sample_ignored (out_sample_ignored),
    .out_tx_busy        (out_tx_busy),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // end the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic phase_t cycle_phase(input int pos);
    case (pos)
      0:       return 3'd4;
      1:       return 3'd6;
      2:       return 3'd2;
      3:       return 3'd3;
      4:       return 3'd1;
      default: return 3'd5;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic kind, input phase_t ph);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_phase_bits <= ph;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_request(KIND_TICK, phase_t'($urandom_range(7)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // hold the write until the port takes it; lower valid with end_writes
  task automatic write_reg(input cfg_idx_t idx, input char_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_chars(input char_t up_ch, input char_t dn_ch, input logic direct);
    write_reg(REG_UP_CHAR, up_ch);
    write_reg(REG_DOWN_CHAR, dn_ch);
    write_reg(REG_DRIVER_PRESENT, {7'd0, direct});
    end_writes();
  endtask

  // mostly legal walks around the cycle with bursts of ticks, some noise
  task automatic run_random(input int count);
    int     roll;
    int     tick_share;
    int     fwd_share;
    phase_t ph;
    tick_share = 50;
    fwd_share  = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        tick_share = $urandom_range(30, 80);
        fwd_share  = $urandom_range(15, 85);
      end
      if ($urandom_range(99) < tick_share) begin
        send_tick();
      end else begin
        roll = $urandom_range(99);
        if (roll < 80) begin
          walk_pos = ($urandom_range(99) < fwd_share) ? (walk_pos + 1) % 6 : (walk_pos + 5) % 6;
          ph = cycle_phase(walk_pos);
        end else if (roll < 88) begin
          ph = cycle_phase(walk_pos);
        end else begin
          ph = phase_t'($urandom_range(7));
          for (int p = 0; p < 6; p++)
            if (cycle_phase(p) == ph) walk_pos = p;
        end
        send_request(KIND_SAMPLE, ph);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset registers, no idling
    send_request(KIND_SAMPLE, 3'd0);
    send_request(KIND_SAMPLE, 3'd7);   // illegal code
    send_request(KIND_SAMPLE, 3'd4);
    send_tick();                       // tick while idle
    send_request(KIND_SAMPLE, 3'd6);   // forward step from idle
    send_request(KIND_SAMPLE, 3'd6);   // no change
    send_request(KIND_SAMPLE, 3'd4);   // reverse step while busy
    send_request(KIND_SAMPLE, 3'd6);   // slot full: dropped
    repeat (10) send_tick();           // finish frame, load waiting char
    send_request(KIND_SAMPLE, 3'd2);
    send_request(KIND_SAMPLE, 3'd3);   // forward step while busy
    repeat (5) send_tick();
    wait_drained();

    set_chars(8'h00, 8'hFF, 1'b1);
    run_random(125);
    wait_drained();

    set_chars(8'hFF, 8'h00, 1'b0);
    send_idle_pct = 67;
    run_random(125);
    wait_drained();

    set_chars(char_t'($urandom_range(255)), char_t'($urandom_range(255)), 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    run_random(125);
    wait_drained();

    set_chars(8'hA5, 8'h5A, 1'b0);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    run_random(125);
    wait_drained();

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
